/* rtl/rcfs_pkg.sv */
// ----------------------------------------------------------------------------
// rcfs_pkg: shared types and constants for the shifted radix-2 FFT core
// Widths, datapath command struct and twiddle ROM generator.
// ----------------------------------------------------------------------------
package rcfs_pkg;

  localparam int unsigned PointsDef      = 512;
  localparam int unsigned TwiddleBitsDef = 18;
  localparam int unsigned SampleW        = 24;
  localparam int unsigned BinW           = 33;
  localparam int unsigned IndexW         = 9;

  localparam logic OpLoad = 1'b0;
  localparam logic OpRead = 1'b1;

  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

  // datapath command from controller
  typedef struct packed {
    logic        wr_sample;  // write loaded sample at addr_a
    logic        rd_a;       // read address a into port a register
    logic        rd_b;       // read address b into port b register
    logic        bfly;       // butterfly on registered a/b, write back
    logic        swap;       // swap a/b write back
    logic        out_rd;     // read for result
  } dp_cmd_t;

  // Q30 cosine/sine by Taylor series, returned as {cos, sin}
  function automatic logic [127:0] taylor(input logic [63:0] x);
    logic [63:0] x2, ts, tc, p;
    logic signed [63:0] ss, cs;
    x2 = (x * x) >> 30;
    ts = x;
    tc = 64'd1 << 30;
    ss = $signed(x);
    cs = $signed(tc);
    for (int n = 1; n <= 7; n++) begin
      p  = (ts * x2) >> 30;
      ts = p / 64'((2 * n) * (2 * n + 1));
      p  = (tc * x2) >> 30;
      tc = p / 64'((2 * n - 1) * (2 * n));
      if ((n & 1) != 0) begin
        ss = ss - $signed(ts);
        cs = cs - $signed(tc);
      end else begin
        ss = ss + $signed(ts);
        cs = cs + $signed(tc);
      end
    end
    return {cs, ss};
  endfunction

  function automatic logic signed [63:0] q30_to_rom(input logic signed [63:0] v,
                                                    input int unsigned Frac);
    logic signed [63:0] r;
    r = (v + (64'sd1 <<< (29 - Frac))) >>> (30 - Frac);
    return r;
  endfunction

  // twiddle entry k: {cos, sin}, each 64 bits signed
  function automatic logic [127:0] tw_entry(input int unsigned k, input int unsigned Points,
                                            input int unsigned Frac);
    int unsigned q, p;
    logic signed [63:0] c, s, cc, ss, oc, os;
    q = (4 * k) / Points;
    p = (4 * k) % Points;
    if (2 * p <= Points) begin
      {c, s} = taylor((HalfPiQ30 * 64'(p) + 64'(Points / 2)) / 64'(Points));
    end else begin
      {s, c} = taylor((HalfPiQ30 * 64'(Points - p) + 64'(Points / 2)) / 64'(Points));
    end
    if (q == 0) begin
      cc = c;
      ss = s;
    end else begin
      cc = -s;
      ss = c;
    end
    oc = (cc < 0) ? -q30_to_rom(-cc, Frac) : q30_to_rom(cc, Frac);
    os = (ss < 0) ? -q30_to_rom(-ss, Frac) : q30_to_rom(ss, Frac);
    return {oc, os};
  endfunction

endpackage

/* rtl/rcfs_datapath.sv */
// ----------------------------------------------------------------------------
// rcfs_datapath: sample memory, twiddle ROM and butterfly unit
// Two-read/one-write sequencing is driven by the controller.
// ----------------------------------------------------------------------------
module rcfs_datapath #(
  parameter int unsigned Points      = rcfs_pkg::PointsDef,
  parameter int unsigned TwiddleBits = rcfs_pkg::TwiddleBitsDef,
  localparam int unsigned AddrW      = $clog2(Points),
  localparam int unsigned TwAddrW    = (AddrW > 1) ? AddrW - 1 : 1
) (
  input  logic                            clk_i,
  input  rcfs_pkg::dp_cmd_t               cmd_i,
  input  logic [AddrW-1:0]                addr_a_i,
  input  logic [AddrW-1:0]                addr_b_i,
  input  logic [TwAddrW-1:0]              tw_addr_i,
  input  logic                            inverse_i,
  input  logic signed [rcfs_pkg::SampleW-1:0] sample_re_i,
  input  logic signed [rcfs_pkg::SampleW-1:0] sample_im_i,
  output logic signed [rcfs_pkg::BinW-1:0]    out_re_o,
  output logic signed [rcfs_pkg::BinW-1:0]    out_im_o
);
  import rcfs_pkg::*;

  localparam int unsigned Frac = TwiddleBits - 1;
  // one extra bit so that +1.0 is held exactly
  localparam int unsigned TwW  = TwiddleBits + 1;
  localparam int unsigned PrW  = BinW + TwW + 1;

  logic [2*BinW-1:0] mem_q [Points];
  logic [2*BinW-1:0] a_q, b_q;
  logic signed [TwW-1:0] wr_q, wi_q;
  logic signed [TwW-1:0] rom_c, rom_s;
  logic [2*TwW-1:0] tw_rom [Points/2];

  // constant twiddle table, {cos, sin} per entry
  for (genvar k = 0; k < Points / 2; k++) begin : g_tw_rom
    localparam logic [127:0] Ent = tw_entry(k, Points, Frac);
    assign tw_rom[k] = {Ent[64+TwW-1:64], Ent[TwW-1:0]};
  end

  // ROM read, registered at time b is read
  always_comb begin
    rom_c = tw_rom[tw_addr_i][2*TwW-1:TwW];
    rom_s = tw_rom[tw_addr_i][TwW-1:0];
  end

  logic signed [BinW-1:0] ar, ai, br, bi;
  assign ar = a_q[2*BinW-1:BinW];
  assign ai = a_q[BinW-1:0];
  assign br = b_q[2*BinW-1:BinW];
  assign bi = b_q[BinW-1:0];

  // products registered before the sum (one multiplier stage)
  logic signed [PrW-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic                  mul_vld_q;
  logic [2*BinW-1:0]     a_d2_q;
  logic [AddrW-1:0]      pa_q, pb_q;

  // second write port use: b half of swap / butterfly, in the cycle after the a half
  logic              wb_pend_q;
  logic [AddrW-1:0]  wb_addr_q;
  logic [2*BinW-1:0] wb_data_q;

  logic signed [PrW:0] tr_s, ti_s;
  logic signed [BinW-1:0] tr, ti, nar, nai;
  always_comb begin
    tr_s = (PrW+1)'(p_rr_q) - (PrW+1)'(p_ii_q) + ((PrW+1)'(1) <<< (Frac - 1));
    ti_s = (PrW+1)'(p_ri_q) + (PrW+1)'(p_ir_q) + ((PrW+1)'(1) <<< (Frac - 1));
    tr   = BinW'(tr_s >>> Frac);
    ti   = BinW'(ti_s >>> Frac);
    nar  = $signed(a_d2_q[2*BinW-1:BinW]);
    nai  = $signed(a_d2_q[BinW-1:0]);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_a || cmd_i.out_rd) begin
      a_q <= mem_q[addr_a_i];
    end
    if (cmd_i.rd_b) begin
      b_q  <= mem_q[addr_b_i];
      wr_q <= rom_c;
      wi_q <= inverse_i ? rom_s : -rom_s;
    end
    mul_vld_q <= cmd_i.bfly;
    if (cmd_i.bfly) begin
      p_rr_q <= PrW'(wr_q * br);
      p_ii_q <= PrW'(wi_q * bi);
      p_ri_q <= PrW'(wr_q * bi);
      p_ir_q <= PrW'(wi_q * br);
      a_d2_q <= a_q;
      pa_q   <= addr_a_i;
      pb_q   <= addr_b_i;
    end
    if (cmd_i.wr_sample) begin
      mem_q[addr_a_i] <= {BinW'(sample_re_i), BinW'(sample_im_i)};
    end else if (cmd_i.swap) begin
      mem_q[addr_a_i] <= b_q;
    end else if (mul_vld_q) begin
      mem_q[pa_q] <= {nar + tr, nai + ti};
    end
    // b half lands in the cycle after the a half, never in the same cycle
    if (wb_pend_q) begin
      mem_q[wb_addr_q] <= wb_data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    wb_pend_q <= cmd_i.swap || mul_vld_q;
    if (cmd_i.swap) begin
      wb_addr_q <= addr_b_i;
      wb_data_q <= a_q;
    end else if (mul_vld_q) begin
      wb_addr_q <= pb_q;
      wb_data_q <= {nar - tr, nai - ti};
    end
  end

  assign out_re_o = $signed(a_q[2*BinW-1:BinW]);
  assign out_im_o = $signed(a_q[BinW-1:0]);

endmodule

/* rtl/rcfs_ctrl.sv */
// ----------------------------------------------------------------------------
// rcfs_ctrl: sequencer for load, shuffle passes, butterflies and reads
// Each swap or butterfly runs through every slot_q value before the next, so writes never collide.
// ----------------------------------------------------------------------------
module rcfs_ctrl #(
  parameter int unsigned Points = rcfs_pkg::PointsDef,
  localparam int unsigned AddrW   = $clog2(Points),
  localparam int unsigned TwAddrW = (AddrW > 1) ? AddrW - 1 : 1,
  localparam int unsigned StW     = $clog2(AddrW + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  op_i,
  output logic                  busy_o,
  output rcfs_pkg::dp_cmd_t     cmd_o,
  output logic [AddrW-1:0]      addr_a_o,
  output logic [AddrW-1:0]      addr_b_o,
  output logic [TwAddrW-1:0]    tw_addr_o,
  output logic                  res_vld_o,
  output logic                  res_status_o,
  output logic [AddrW-1:0]      res_index_o,
  output logic                  res_last_o
);
  import rcfs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SWAP1, S_REV, S_BFLY, S_SWAP2, S_READ
  } state_e;

  state_e           state_q;
  logic [AddrW-1:0] load_cnt_q, read_cnt_q, idx_q;
  logic [StW-1:0]   stage_q;
  logic [1:0]       slot_q;
  logic             ready_q;
  logic             res_vld_q, res_st_q, res_last_q;
  logic [AddrW-1:0] res_idx_q;

  function automatic logic [AddrW-1:0] bitrev(input logic [AddrW-1:0] v);
    logic [AddrW-1:0] r;
    for (int b = 0; b < AddrW; b++) begin
      r[AddrW-1-b] = v[b];
    end
    return r;
  endfunction

  // butterfly addressing: stage s (0-based), h = 2^s, pair index idx_q
  logic [AddrW-1:0] lo_mask, j_val, a_addr, b_addr, hstep;
  logic [AddrW:0]   tw_full;
  always_comb begin
    hstep   = AddrW'(1) << stage_q;
    lo_mask = hstep - AddrW'(1);
    j_val   = idx_q & lo_mask;
    a_addr  = ((idx_q & ~lo_mask) << 1) | j_val;
    b_addr  = a_addr | hstep;
    tw_full = (AddrW+1)'(j_val) << (AddrW - 1 - stage_q);
  end

  logic [AddrW-1:0] rev_idx;
  assign rev_idx = bitrev(idx_q);

  always_comb begin
    cmd_o     = '0;
    addr_a_o  = idx_q;
    addr_b_o  = idx_q;
    tw_addr_o = TwAddrW'(tw_full);
    case (state_q)
      S_IDLE: begin
        addr_a_o = start_i && (op_i == OpRead) ? read_cnt_q : load_cnt_q;
        cmd_o.wr_sample = start_i && (op_i == OpLoad);
        cmd_o.out_rd    = start_i && (op_i == OpRead);
      end
      S_SWAP1, S_SWAP2: begin
        addr_a_o   = idx_q;
        addr_b_o   = idx_q ^ AddrW'(Points / 2);
        cmd_o.rd_a = (slot_q == 2'd0);
        cmd_o.rd_b = (slot_q == 2'd0);
        cmd_o.swap = (slot_q == 2'd1);
      end
      S_REV: begin
        addr_a_o   = idx_q;
        addr_b_o   = rev_idx;
        cmd_o.rd_a = (slot_q == 2'd0) && (rev_idx > idx_q);
        cmd_o.rd_b = (slot_q == 2'd0) && (rev_idx > idx_q);
        cmd_o.swap = (slot_q == 2'd1) && (rev_idx > idx_q);
      end
      S_BFLY: begin
        addr_a_o   = a_addr;
        addr_b_o   = b_addr;
        cmd_o.rd_a = (slot_q == 2'd0);
        cmd_o.rd_b = (slot_q == 2'd0);
        cmd_o.bfly = (slot_q == 2'd1);
      end
      default: ;
    endcase
  end

  logic last_idx_half, last_idx_full;
  assign last_idx_half = (idx_q == AddrW'(Points / 2 - 1));
  assign last_idx_full = (idx_q == AddrW'(Points - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      load_cnt_q <= '0;
      read_cnt_q <= '0;
      idx_q      <= '0;
      stage_q    <= '0;
      slot_q     <= '0;
      ready_q    <= 1'b0;
      res_vld_q  <= 1'b0;
      res_st_q   <= 1'b0;
      res_idx_q  <= '0;
      res_last_q <= 1'b0;
    end else begin
      res_vld_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            if (op_i == OpLoad) begin
              ready_q    <= 1'b0;
              read_cnt_q <= '0;
              load_cnt_q <= load_cnt_q + AddrW'(1);
              if (load_cnt_q == AddrW'(Points - 1)) begin
                state_q <= S_SWAP1;
                idx_q   <= '0;
                slot_q  <= '0;
              end
            end else begin
              state_q    <= S_READ;
              res_st_q   <= !ready_q;
              res_idx_q  <= ready_q ? read_cnt_q : '0;
              res_last_q <= ready_q && (read_cnt_q == AddrW'(Points - 1));
              if (ready_q) begin
                read_cnt_q <= read_cnt_q + AddrW'(1);
                if (read_cnt_q == AddrW'(Points - 1)) begin
                  ready_q <= 1'b0;
                end
              end
            end
          end
        end
        S_READ: begin
          res_vld_q <= 1'b1;
          state_q   <= S_IDLE;
        end
        S_SWAP1, S_SWAP2, S_REV, S_BFLY: begin
          slot_q <= slot_q + 2'd1;
          if (slot_q == 2'd3) begin
            idx_q <= idx_q + AddrW'(1);
            case (state_q)
              S_SWAP1: if (last_idx_half) begin
                state_q <= S_REV;
                idx_q   <= '0;
              end
              S_REV: if (last_idx_full) begin
                state_q <= S_BFLY;
                idx_q   <= '0;
                stage_q <= '0;
              end
              S_BFLY: if (last_idx_half) begin
                idx_q <= '0;
                if (stage_q == StW'(AddrW - 1)) begin
                  state_q <= S_SWAP2;
                end else begin
                  stage_q <= stage_q + StW'(1);
                end
              end
              default: if (last_idx_half) begin
                state_q <= S_IDLE;
                ready_q <= 1'b1;
                idx_q   <= '0;
              end
            endcase
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o       = (state_q != S_IDLE);
  assign res_vld_o    = res_vld_q;
  assign res_status_o = res_st_q;
  assign res_index_o  = res_idx_q;
  assign res_last_o   = res_last_q;

endmodule

/* rtl/radix2_complex_fft_shifted_core.sv */
// ----------------------------------------------------------------------------
// radix2_complex_fft_shifted_core: shifted in-place radix-2 complex FFT
// Loads POINTS samples, transforms with half swaps, returns bins on reads.
// ----------------------------------------------------------------------------
// Load transfer: each start with OpLoad writes one sample. The POINTS-th load
//   runs the transform: half swap, bit-reverse, butterfly stages, half swap,
//   all on the sample memory shared by every swap and butterfly.
// Read transfer: start enters S_READ (busy high), which registers the result strobe.
// Results cannot be stalled. Reset (rst_ni low, async) clears counters,
//   frame-ready and inverse_q; the sample memory is not cleared.
module radix2_complex_fft_shifted_core #(
  parameter int unsigned POINTS       = rcfs_pkg::PointsDef,
  parameter int unsigned TWIDDLE_BITS = rcfs_pkg::TwiddleBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                cfg_we_i,
  input  logic                                cfg_wdata_i,
  input  logic                                op_i,
  input  logic signed [rcfs_pkg::SampleW-1:0] sample_re_i,
  input  logic signed [rcfs_pkg::SampleW-1:0] sample_im_i,
  output logic                                done_o,
  output logic signed [rcfs_pkg::BinW-1:0]    bin_re_o,
  output logic signed [rcfs_pkg::BinW-1:0]    bin_im_o,
  output logic [rcfs_pkg::IndexW-1:0]         bin_index_o,
  output logic                                last_bin_o,
  output logic                                status_o
);
  import rcfs_pkg::*;

  localparam int unsigned AddrW   = $clog2(POINTS);
  localparam int unsigned TwAddrW = (AddrW > 1) ? AddrW - 1 : 1;

  logic inverse_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inverse_q <= 1'b0;
    end else if (cfg_we_i) begin
      inverse_q <= cfg_wdata_i;
    end
  end

  dp_cmd_t              cmd;
  logic [AddrW-1:0]     addr_a, addr_b, res_idx;
  logic [TwAddrW-1:0]   tw_addr;
  logic                 res_vld, res_st, res_last;
  logic signed [BinW-1:0] out_re, out_im;

  rcfs_ctrl #(.Points(POINTS)) u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .op_i, .busy_o(busy), .cmd_o(cmd),
    .addr_a_o(addr_a), .addr_b_o(addr_b), .tw_addr_o(tw_addr),
    .res_vld_o(res_vld), .res_status_o(res_st), .res_index_o(res_idx),
    .res_last_o(res_last)
  );

  rcfs_datapath #(.Points(POINTS), .TwiddleBits(TWIDDLE_BITS)) u_dp (
    .clk_i, .cmd_i(cmd), .addr_a_i(addr_a), .addr_b_i(addr_b), .tw_addr_i(tw_addr),
    .inverse_i(inverse_q), .sample_re_i, .sample_im_i,
    .out_re_o(out_re), .out_im_o(out_im)
  );

  // a status-1 result carries zeros
  assign done_o      = res_vld;
  assign status_o    = res_st;
  assign bin_re_o    = res_st ? '0 : out_re;
  assign bin_im_o    = res_st ? '0 : out_im;
  assign bin_index_o = IndexW'(res_idx);
  assign last_bin_o  = res_last;

  // a read transfer accepted while idle strobes done_o
  a_read_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && op_i == OpRead) |=> ##1 done_o)
    else $error("read transfer without result");
  // a load transfer accepted while idle does not strobe done_o
  a_load_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && op_i == OpLoad) |=> ##1 !done_o)
    else $error("result after load transfer");
  // failure status carries no last mark
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o |-> !last_bin_o && bin_index_o == '0)
    else $error("status-1 result with index or last mark");

endmodule
